// ===== sv/tto_pkg.sv =====
// Shared constants, store geometry and request codes for the tile text overlay compositor.
`timescale 1ns / 1ps

package tto_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 192;
    localparam int MAP_COLUMNS   = 32;
    localparam int TILE_COUNT    = 1024;

    localparam int BITMAP_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int PALETTE_DEPTH = 256;
    localparam int MAP_DEPTH     = 1024;
    localparam int TILE_BYTES    = 32;
    localparam int TILE_DEPTH    = TILE_COUNT * TILE_BYTES;

    localparam int BITMAP_AW  = $clog2(BITMAP_DEPTH);
    localparam int PALETTE_AW = $clog2(PALETTE_DEPTH);
    localparam int MAP_AW     = $clog2(MAP_DEPTH);
    localparam int TILE_AW    = $clog2(TILE_DEPTH);
    localparam int TILE_IDX_W = $clog2(TILE_COUNT);

    localparam int COLOR_W = 15;
    localparam int MAP_W   = 16;
    localparam int BYTE_W  = 8;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 15'h7FFF;

    localparam int PADDR_W = 3;

    typedef enum logic [2:0] {
        FUNC_BITMAP_WR = 3'd0,
        FUNC_PALETTE_WR = 3'd1,
        FUNC_MAP_WR    = 3'd2,
        FUNC_TILE_WR   = 3'd3,
        FUNC_RENDER    = 3'd4,
        FUNC_CONVERT   = 3'd5
    } t_func;

    typedef enum logic [0:0] {
        REG_TEXT_COLOR = 1'b0
    } t_reg_idx;

endpackage

// ===== sv/tto_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read-first output.
`timescale 1ns / 1ps

module tto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tile_text_overlay_compositor.sv =====
// Top level: store loading, three-stage render pipeline and APB register for text color.
//
// Requests enter on i_valid/o_stall with fields i_func, i_addr, i_wdata, i_pix_x, i_pix_y.
// Store writes (bitmap, palette, map, tile) take effect at the accepting edge and give no
// result. Render and convert requests each give one result on o_valid/i_stall with blue,
// green and red bytes and text_hit; a render outside the screen gives none.
// Pipeline: bitmap and map reads in the first stage, palette and tile reads in the second,
// color select into the output register. A result passes through the first-stage, second-stage
// and output registers; one request is taken per cycle, sustained, while o_stall is low.
// When i_stall holds the output register, the stages behind it keep filling; o_stall rises
// only once every stage holds a result, and falls in the cycle the output is taken.
// The four stores are plain synchronous RAMs with no reset; their contents are undefined
// until written. Reset (synchronous, i_rst_n low) empties the pipeline and sets text color
// to white. The text color register is at APB byte address 0; it is to be written only while
// the block is idle, which the user must ensure, as the block itself does not enforce it.
`timescale 1ns / 1ps

module tile_text_overlay_compositor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_func,
    input  logic [15:0]                  i_addr,
    input  logic [15:0]                  i_wdata,
    input  logic [7:0]                   i_pix_x,
    input  logic [7:0]                   i_pix_y,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_blue_byte,
    output logic [7:0]                   o_green_byte,
    output logic [7:0]                   o_red_byte,
    output logic                         o_text_hit,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tto_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // config register
    logic [tto_pkg::COLOR_W-1:0] r_text_color;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == tto_pkg::REG_TEXT_COLOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tto_pkg::TEXT_COLOR_RESET;
        end else if (cfg_wr) begin
            r_text_color <= pwdata[tto_pkg::COLOR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tto_pkg::REG_TEXT_COLOR) begin
            prdata = 32'(r_text_color);
        end
    end

    // pipeline registers
    logic                        r_s1_valid, r_s2_valid, r_out_valid;
    logic                        r_s1_conv, r_s2_conv;
    logic [tto_pkg::COLOR_W-1:0] r_s1_raw, r_s2_raw;
    logic [2:0]                  r_s1_ylo;
    logic [1:0]                  r_s1_xmid;
    logic                        r_s1_xodd, r_s2_xodd;
    logic [tto_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_hit;

    logic ld_out, ld2, ld1, acc;

    assign ld_out  = !r_out_valid || !i_stall;
    assign ld2     = !r_s2_valid || ld_out;
    assign ld1     = !r_s1_valid || ld2;
    assign o_stall = !ld1;
    assign acc     = i_valid && ld1;

    // request decode
    logic on_screen, is_render, is_conv;
    logic bm_we, pal_we, map_we, tile_we;

    assign on_screen = (9'(i_pix_x) < 9'(tto_pkg::SCREEN_WIDTH)) &&
                       (9'(i_pix_y) < 9'(tto_pkg::SCREEN_HEIGHT));

    always_comb begin
        is_render = 1'b0;
        is_conv   = 1'b0;
        bm_we     = 1'b0;
        pal_we    = 1'b0;
        map_we    = 1'b0;
        tile_we   = 1'b0;
        unique case (i_func)
            tto_pkg::FUNC_BITMAP_WR:  bm_we   = 17'(i_addr) < 17'(tto_pkg::BITMAP_DEPTH);
            tto_pkg::FUNC_PALETTE_WR: pal_we  = 17'(i_addr) < 17'(tto_pkg::PALETTE_DEPTH);
            tto_pkg::FUNC_MAP_WR:     map_we  = 17'(i_addr) < 17'(tto_pkg::MAP_DEPTH);
            tto_pkg::FUNC_TILE_WR:    tile_we = 17'(i_addr) < 17'(tto_pkg::TILE_DEPTH);
            tto_pkg::FUNC_RENDER:     is_render = on_screen;
            tto_pkg::FUNC_CONVERT:    is_conv   = 1'b1;
            default: ;
        endcase
    end

    // stage 1 addresses
    logic [15:0] bm_raddr_full, cell_full;

    assign bm_raddr_full = 16'(i_pix_y) * 16'(tto_pkg::SCREEN_WIDTH) + 16'(i_pix_x);
    assign cell_full     = 16'(i_pix_y[7:3]) * 16'(tto_pkg::MAP_COLUMNS) + 16'(i_pix_x[7:3]);

    logic [tto_pkg::BYTE_W-1:0]  bm_q;
    logic [tto_pkg::MAP_W-1:0]   map_q;
    logic [tto_pkg::COLOR_W-1:0] pal_q;
    logic [tto_pkg::BYTE_W-1:0]  tile_q;
    logic [tto_pkg::TILE_AW-1:0] tile_raddr;

    tto_ram #(.WIDTH(tto_pkg::BYTE_W), .DEPTH(tto_pkg::BITMAP_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (acc && bm_we),
        .i_waddr (i_addr[tto_pkg::BITMAP_AW-1:0]),
        .i_wdata (i_wdata[tto_pkg::BYTE_W-1:0]),
        .i_re    (ld1),
        .i_raddr (bm_raddr_full[tto_pkg::BITMAP_AW-1:0]),
        .o_rdata (bm_q)
    );

    tto_ram #(.WIDTH(tto_pkg::MAP_W), .DEPTH(tto_pkg::MAP_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (acc && map_we),
        .i_waddr (i_addr[tto_pkg::MAP_AW-1:0]),
        .i_wdata (i_wdata),
        .i_re    (ld1),
        .i_raddr (cell_full[tto_pkg::MAP_AW-1:0]),
        .o_rdata (map_q)
    );

    // tile byte = tile*32 + row*4 + column pair
    assign tile_raddr = {map_q[tto_pkg::TILE_IDX_W-1:0], r_s1_ylo, r_s1_xmid};

    tto_ram #(.WIDTH(tto_pkg::COLOR_W), .DEPTH(tto_pkg::PALETTE_DEPTH)) u_palette (
        .i_clk   (i_clk),
        .i_we    (acc && pal_we),
        .i_waddr (i_addr[tto_pkg::PALETTE_AW-1:0]),
        .i_wdata (i_wdata[tto_pkg::COLOR_W-1:0]),
        .i_re    (ld2),
        .i_raddr (bm_q[tto_pkg::PALETTE_AW-1:0]),
        .o_rdata (pal_q)
    );

    tto_ram #(.WIDTH(tto_pkg::BYTE_W), .DEPTH(tto_pkg::TILE_DEPTH)) u_tile (
        .i_clk   (i_clk),
        .i_we    (acc && tile_we),
        .i_waddr (i_addr[tto_pkg::TILE_AW-1:0]),
        .i_wdata (i_wdata[tto_pkg::BYTE_W-1:0]),
        .i_re    (ld2),
        .i_raddr (tile_raddr),
        .o_rdata (tile_q)
    );

    // stage 3 color select
    logic [3:0]                  nib;
    logic                        hit;
    logic [tto_pkg::COLOR_W-1:0] n_out_color;

    assign nib = r_s2_xodd ? tile_q[7:4] : tile_q[3:0];
    assign hit = !r_s2_conv && (nib != 4'd0);

    always_comb begin
        if (r_s2_conv) begin
            n_out_color = r_s2_raw;
        end else if (hit) begin
            n_out_color = r_text_color;
        end else begin
            n_out_color = pal_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld1) begin
                r_s1_valid <= acc && (is_render || is_conv);
            end
            if (ld2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ld_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_conv <= is_conv;
            r_s1_raw  <= i_wdata[tto_pkg::COLOR_W-1:0];
            r_s1_ylo  <= i_pix_y[2:0];
            r_s1_xmid <= i_pix_x[2:1];
            r_s1_xodd <= i_pix_x[0];
        end
        if (ld2) begin
            r_s2_conv <= r_s1_conv;
            r_s2_raw  <= r_s1_raw;
            r_s2_xodd <= r_s1_xodd;
        end
        if (ld_out) begin
            r_out_color <= n_out_color;
            r_out_hit   <= hit;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_blue_byte  = {r_out_color[14:10], 3'b000};
    assign o_green_byte = {r_out_color[9:5], 3'b000};
    assign o_red_byte   = {r_out_color[4:0], 3'b000};
    assign o_text_hit   = r_out_hit;

    // checks
    a_offscreen_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_func == tto_pkg::FUNC_RENDER) && !on_screen |=> !r_s1_valid)
        else $error("off-screen render entered pipeline");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (bm_we || pal_we || map_we || tile_we) |=> !r_s1_valid)
        else $error("store write produced a result");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_s2_valid && r_out_valid && i_stall)
        else $error("request stalled with room in pipeline");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !ld_out |=> r_s2_valid && $stable(r_s2_raw) && $stable(tile_q))
        else $error("held stage two lost its data");

endmodule

// ===== test/tile_text_overlay_compositor_test.sv =====
// Self-checking testbench for the tile text overlay compositor: store loads, renders, converts.
`timescale 1ns / 1ps

module tile_text_overlay_compositor_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WINDOW       = 16;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       hit;
    } t_pixel;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [2:0]                   i_func;
    logic [15:0]                  i_addr;
    logic [15:0]                  i_wdata;
    logic [7:0]                   i_pix_x;
    logic [7:0]                   i_pix_y;
    logic                         o_valid;
    logic                         i_stall;
    logic [7:0]                   o_blue_byte;
    logic [7:0]                   o_green_byte;
    logic [7:0]                   o_red_byte;
    logic                         o_text_hit;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [tto_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    tile_text_overlay_compositor DUT (.*);

    // shadow copy of the block's stores, with a written flag per entry
    logic [7:0]   bitmap_img  [tto_pkg::BITMAP_DEPTH];
    logic [14:0]  palette_img [tto_pkg::PALETTE_DEPTH];
    logic [15:0]  map_img     [tto_pkg::MAP_DEPTH];
    logic [7:0]   tile_img    [tto_pkg::TILE_DEPTH];
    bit           bitmap_wr   [tto_pkg::BITMAP_DEPTH];
    bit           palette_wr  [tto_pkg::PALETTE_DEPTH];
    bit           map_wr      [tto_pkg::MAP_DEPTH];
    bit           tile_wr     [tto_pkg::TILE_DEPTH];
    logic [14:0]  text_color_shadow = tto_pkg::TEXT_COLOR_RESET;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     sink_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pixel expand_rgb555(logic [14:0] c, logic hit);
        return '{blue: {c[14:10], 3'b000}, green: {c[9:5], 3'b000},
                 red: {c[4:0], 3'b000}, hit: hit};
    endfunction

    function automatic int tile_byte_addr(int tile, logic [7:0] x, logic [7:0] y);
        return (tile % tto_pkg::TILE_COUNT) * tto_pkg::TILE_BYTES + int'(y[2:0]) * 4
               + int'(x[2:1]);
    endfunction

    function automatic int map_cell(logic [7:0] x, logic [7:0] y);
        return ((int'(y) >> 3) * tto_pkg::MAP_COLUMNS + (int'(x) >> 3)) % tto_pkg::MAP_DEPTH;
    endfunction

    // applies one accepted request to the shadow state, queues its pixel if any
    function automatic void composite_request(logic [2:0] func, logic [15:0] addr,
                                              logic [15:0] wdata, logic [7:0] x,
                                              logic [7:0] y);
        int          pix_idx;
        logic [14:0] color;
        logic [7:0]  tbyte;
        logic [3:0]  nib;
        case (func)
            tto_pkg::FUNC_BITMAP_WR: if (addr < tto_pkg::BITMAP_DEPTH) begin
                bitmap_img[addr] = wdata[7:0];
                bitmap_wr[addr]  = 1'b1;
            end
            tto_pkg::FUNC_PALETTE_WR: if (addr < tto_pkg::PALETTE_DEPTH) begin
                palette_img[addr] = wdata[14:0];
                palette_wr[addr]  = 1'b1;
            end
            tto_pkg::FUNC_MAP_WR: if (addr < tto_pkg::MAP_DEPTH) begin
                map_img[addr] = wdata;
                map_wr[addr]  = 1'b1;
            end
            tto_pkg::FUNC_TILE_WR: if (addr < tto_pkg::TILE_DEPTH) begin
                tile_img[addr] = wdata[7:0];
                tile_wr[addr]  = 1'b1;
            end
            tto_pkg::FUNC_RENDER: if (int'(x) < tto_pkg::SCREEN_WIDTH &&
                                      int'(y) < tto_pkg::SCREEN_HEIGHT) begin
                pix_idx = int'(y) * tto_pkg::SCREEN_WIDTH + int'(x);
                color   = palette_img[bitmap_img[pix_idx]];
                tbyte   = tile_img[tile_byte_addr(int'(map_img[map_cell(x, y)][9:0]), x, y)];
                nib     = x[0] ? tbyte[7:4] : tbyte[3:0];
                if (nib != 4'd0)
                    expected_pixels.push_back(expand_rgb555(text_color_shadow, 1'b1));
                else
                    expected_pixels.push_back(expand_rgb555(color, 1'b0));
            end
            tto_pkg::FUNC_CONVERT: expected_pixels.push_back(expand_rgb555(wdata[14:0], 1'b0));
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] func, input logic [15:0] addr,
                                input logic [15:0] wdata, input logic [7:0] x,
                                input logic [7:0] y);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_addr  <= addr;
        i_wdata <= wdata;
        i_pix_x <= x;
        i_pix_y <= y;
        do @(posedge i_clk); while (o_stall);
        composite_request(func, addr, wdata, x, y);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_text_color(input logic [14:0] value);
        wait_for_drain();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tto_pkg::PADDR_W'(4 * int'(tto_pkg::REG_TEXT_COLOR));
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        text_color_shadow = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // loads every store entry a render of (x, y) will read that is still unwritten
    task automatic prepare_pixel(input logic [7:0] x, input logic [7:0] y);
        int pix_idx;
        int cell_idx;
        int tbyte_addr;
        pix_idx  = int'(y) * tto_pkg::SCREEN_WIDTH + int'(x);
        cell_idx = map_cell(x, y);
        if (!bitmap_wr[pix_idx])
            send_request(tto_pkg::FUNC_BITMAP_WR, 16'(pix_idx), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if (!palette_wr[bitmap_img[pix_idx]])
            send_request(tto_pkg::FUNC_PALETTE_WR, 16'(bitmap_img[pix_idx]),
                         16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if (!map_wr[cell_idx])
            send_request(tto_pkg::FUNC_MAP_WR, 16'(cell_idx), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        tbyte_addr = tile_byte_addr(int'(map_img[cell_idx][9:0]), x, y);
        if (!tile_wr[tbyte_addr])
            send_request(tto_pkg::FUNC_TILE_WR, 16'(tbyte_addr), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_corner_requests();
        // out-of-range writes must not alias onto low entries
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'(tto_pkg::BITMAP_DEPTH), 16'h00AA, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_PALETTE_WR, 16'(tto_pkg::PALETTE_DEPTH), 16'h1234, 8'd0,
                     8'd0);
        send_request(tto_pkg::FUNC_MAP_WR, 16'(tto_pkg::MAP_DEPTH), 16'h0155, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_TILE_WR, 16'(tto_pkg::TILE_DEPTH), 16'h00FF, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        // top-left cell: narrow writes, map index with high bits set, nibble per x parity
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'd0, 16'hFF05, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'd1, 16'h0005, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_PALETTE_WR, 16'd5, 16'hFC21, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_MAP_WR, 16'd0, 16'hFC03, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_TILE_WR, 16'(3 * tto_pkg::TILE_BYTES), 16'h0010, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_RENDER, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_RENDER, 16'hFFFF, 16'hFFFF, 8'd1, 8'd0);
        // bottom-right corner, last tile, last tile byte
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'(tto_pkg::BITMAP_DEPTH - 1), 16'h0000, 8'd0,
                     8'd0);
        send_request(tto_pkg::FUNC_BITMAP_WR, 16'(tto_pkg::BITMAP_DEPTH - 2), 16'h0000, 8'd0,
                     8'd0);
        send_request(tto_pkg::FUNC_PALETTE_WR, 16'd0, 16'h0000, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_MAP_WR, 16'(map_cell(8'd255, 8'd191)), 16'hFFFF, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_TILE_WR, 16'(tto_pkg::TILE_DEPTH - 1), 16'h000F, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_RENDER, 16'd0, 16'd0, 8'd255, 8'd191);
        send_request(tto_pkg::FUNC_RENDER, 16'd0, 16'd0, 8'd254, 8'd191);
        // off-screen renders give nothing
        send_request(tto_pkg::FUNC_RENDER, 16'd0, 16'd0, 8'd0, 8'd192);
        send_request(tto_pkg::FUNC_RENDER, 16'd0, 16'd0, 8'd255, 8'd255);
        send_request(tto_pkg::FUNC_CONVERT, 16'd0, 16'h0000, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_CONVERT, 16'd0, 16'hFFFF, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_CONVERT, 16'd0, 16'h8000, 8'd0, 8'd0);
        send_request(tto_pkg::FUNC_CONVERT, 16'd0, 16'h7C1F, 8'd0, 8'd0);
        send_request(FUNC_RSVD6, 16'h5A5A, 16'hA5A5, 8'd3, 8'd3);
        send_request(FUNC_RSVD7, 16'hA5A5, 16'h5A5A, 8'd4, 8'd4);
        wait_for_drain();
    endtask

    task automatic test_traffic_phase(input logic [14:0] color, input int idle_pct,
                                      input int stall_pct, input int ops);
        int          win_x;
        int          win_y;
        int          sel;
        int          depth;
        logic [2:0]  func;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] addr;
        set_text_color(color);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        win_x = $urandom_range(0, tto_pkg::SCREEN_WIDTH - WINDOW);
        win_y = $urandom_range(0, tto_pkg::SCREEN_HEIGHT - WINDOW);
        for (int i = 0; i < ops; i++) begin
            // halfway through, the sender holds off until the pipeline is empty
            if (i == ops / 2)
                wait_for_drain();
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                if (sel < 42) begin
                    x = 8'(win_x + $urandom_range(0, WINDOW - 1));
                    y = 8'(win_y + $urandom_range(0, WINDOW - 1));
                end else begin
                    x = 8'($urandom_range(0, tto_pkg::SCREEN_WIDTH - 1));
                    y = 8'($urandom_range(0, tto_pkg::SCREEN_HEIGHT - 1));
                end
                prepare_pixel(x, y);
                send_request(tto_pkg::FUNC_RENDER, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), x, y);
            end else if (sel < 70) begin
                send_request(tto_pkg::FUNC_CONVERT, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (sel < 88) begin
                func  = 3'($urandom_range(tto_pkg::FUNC_BITMAP_WR, tto_pkg::FUNC_TILE_WR));
                depth = (func == tto_pkg::FUNC_BITMAP_WR)  ? tto_pkg::BITMAP_DEPTH  :
                        (func == tto_pkg::FUNC_PALETTE_WR) ? tto_pkg::PALETTE_DEPTH :
                        (func == tto_pkg::FUNC_MAP_WR)     ? tto_pkg::MAP_DEPTH     :
                                                             tto_pkg::TILE_DEPTH;
                if ($urandom_range(0, 99) < 15)
                    addr = 16'($urandom_range(0, 65535));
                else if (func == tto_pkg::FUNC_BITMAP_WR && $urandom_range(0, 1))
                    addr = 16'((win_y + $urandom_range(0, WINDOW - 1)) * tto_pkg::SCREEN_WIDTH
                               + win_x + $urandom_range(0, WINDOW - 1));
                else
                    addr = 16'($urandom_range(0, depth - 1));
                send_request(func, addr, 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (sel < 95) begin
                send_request(tto_pkg::FUNC_RENDER, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(tto_pkg::SCREEN_HEIGHT, 255)));
            end else begin
                send_request(sel[0] ? FUNC_RSVD7 : FUNC_RSVD6, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            end
        end
        wait_for_drain();
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{blue: o_blue_byte, green: o_green_byte, red: o_red_byte, hit: o_text_hit};
            if (expected_pixels.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result b=%h g=%h r=%h hit=%b", $realtime,
                             got.blue, got.green, got.red, got.hit);
                mismatch_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display("%0t: expected b=%h g=%h r=%h hit=%b, got b=%h g=%h r=%h hit=%b",
                                 $realtime, want.blue, want.green, want.red, want.hit,
                                 got.blue, got.green, got.red, got.hit);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tile_text_overlay_compositor_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func  = tto_pkg::FUNC_CONVERT;
        i_addr  = '0;
        i_wdata = '0;
        i_pix_x = '0;
        i_pix_y = '0;
        i_stall = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_requests();
        test_traffic_phase(15'h0000, 0, 0, 40);
        test_traffic_phase(15'($urandom_range(1, 32766)), 51, 0, 40);
        test_traffic_phase(15'h7FFF, 0, 51, 40);
        test_traffic_phase(15'($urandom_range(1, 32766)), 34, 34, 40);
        wait_for_drain();

        if (mismatch_count == 0)
            $display("tile_text_overlay_compositor_test: PASS");
        else
            $display("tile_text_overlay_compositor_test: FAIL");
        $finish;
    end

endmodule

// ===== tile_text_overlay_compositor.f =====
sv/tto_pkg.sv
sv/tto_ram.sv
sv/tile_text_overlay_compositor.sv
test/tile_text_overlay_compositor_test.sv
